// ===== rtl/rcpn_pkg.sv =====
// Package for the fixed-point Newton-Raphson reciprocal unit.
// Holds the constants and the normalization record shared by the top level and the step stages.
// Depends on nothing.
package rcpn_pkg;

	localparam int unsigned DIV_W   = 18;
	localparam int unsigned RCP_W   = 32;
	localparam int unsigned XN_W    = 15;
	localparam int unsigned SHL_W   = 4;
	localparam int unsigned SHR_W   = 2;
	localparam int unsigned NEWTON_STEPS = 3;

	localparam logic [31:0] COEF_A  = 32'h0000_F0F1;
	localparam logic [31:0] COEF_B  = 32'hB4B4_B4B5;
	localparam logic [31:0] ONE_Q15 = 32'h0000_7FFF;

	// Normalized divisor and the shifts that undo the normalization at the end.
	typedef struct packed {
		logic [XN_W-1:0]  xn;
		logic [SHL_W-1:0] shl;
		logic [SHR_W-1:0] shr;
	} norm_t;

endpackage

// ===== rtl/rcpn_step.sv =====
// One Newton-Raphson refinement of the reciprocal estimate, split over two register stages.
// Depends on rcpn_pkg for the constants and the normalization record.
module rcpn_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               src_valid,
	input  logic [31:0]        src_y,
	input  rcpn_pkg::norm_t    src_norm,
	output logic               res_valid,
	output logic [31:0]        res_y,
	output rcpn_pkg::norm_t    res_norm
);

	logic [16:0]       y0_a;
	logic [31:0]       prod_a;
	logic              vld_s1;
	logic [31:0]       y_s1;
	logic [16:0]       t_s1;
	rcpn_pkg::norm_t   norm_s1;
	logic [16:0]       y0_b;
	logic [31:0]       corr_b;
	logic [31:0]       prod_b;
	logic              vld_s2;
	logic [31:0]       y_s2;
	rcpn_pkg::norm_t   norm_s2;

	// First half: t = (xn * y0) >> 15; the product fits in 32 bits.
	assign y0_a   = src_y[31:15];
	assign prod_a = {17'd0, src_norm.xn} * {15'd0, y0_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1    <= src_y;
			t_s1    <= prod_a[31:15];
			norm_s1 <= src_norm;
		end
	end

	// Second half: y + y0 * (32767 - t), wrapping modulo 2^32.
	assign y0_b   = y_s1[31:15];
	assign corr_b = rcpn_pkg::ONE_Q15 - {15'd0, t_s1};
	assign prod_b = {15'd0, y0_b} * corr_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2    <= y_s1 + prod_b;
			norm_s2 <= norm_s1;
		end
	end

	assign res_valid = vld_s2;
	assign res_y     = y_s2;
	assign res_norm  = norm_s2;

endmodule

// ===== rtl/fixed_point_reciprocal_newton.sv =====
// Top level of the fixed-point Newton-Raphson reciprocal unit (Q2.16 in, Q10.22 out).
// Depends on rcpn_pkg and instantiates rcpn_step once for each refinement.
//
//   Channel      Signals                                      Direction  Width
//   divisor      divisor_valid, divisor_ready, divisor         in         18
//   reciprocal   reciprocal_valid, reciprocal_ready, reciprocal out        32
//
// Every cycle the pipeline may take a new divisor; a transfer on the input needs the
// pipeline to advance. The stages in order are normalize, first estimate, two stages
// for each of the three Newton steps (one multiplier each), and the final rescale,
// which is also the output register. The whole pipeline advances together whenever
// the output register is empty or its transfer completes, so a stall on the output
// freezes every stage and loses or repeats nothing. Reset clears the valid bits only.
module fixed_point_reciprocal_newton (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        divisor_valid,
	output logic        divisor_ready,
	input  logic [17:0] divisor,
	output logic        reciprocal_valid,
	input  logic        reciprocal_ready,
	output logic [31:0] reciprocal
);

	localparam int unsigned N = rcpn_pkg::NEWTON_STEPS;

	logic              adv;
	logic [4:0]        top_bit;
	logic [3:0]        shl_c;
	logic [1:0]        shr_c;
	logic [32:0]       up_c;
	logic [32:0]       dn_c;
	rcpn_pkg::norm_t   norm_c;

	logic              vld_s1;
	rcpn_pkg::norm_t   norm_s1;
	logic              vld_s2;
	logic [31:0]       y_s2;
	rcpn_pkg::norm_t   norm_s2;

	logic              chain_vld  [0:N];
	logic [31:0]       chain_y    [0:N];
	rcpn_pkg::norm_t   chain_norm [0:N];

	logic [23:0]       y_trim;
	logic [31:0]       fin_up;
	logic [31:0]       fin_c;
	logic              vld_s9;
	logic [31:0]       reciprocal_s9;

	// The pipeline moves as a whole when the output register can take a new value.
	assign adv           = !vld_s9 || reciprocal_ready;
	assign divisor_ready = adv;

	// Stage 1: find the highest set bit and normalize into Q0.15. A zero divisor
	// takes the top bit as 0, which leaves xn at zero.
	always_comb begin
		top_bit = 5'd0;
		for (int i = 0; i < 18; i++) begin
			if (divisor[i]) begin
				top_bit = 5'(i);
			end
		end
		shl_c = (top_bit > 5'd15) ? 4'd0 : 4'(5'd15 - top_bit);
		shr_c = (top_bit > 5'd15) ? 2'(top_bit - 5'd15) : 2'd0;
		up_c  = {15'd0, divisor} << shl_c;
		dn_c  = up_c >> ({1'b0, shr_c} + 3'd1);
		norm_c.xn  = dn_c[14:0];
		norm_c.shl = shl_c;
		norm_c.shr = shr_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= divisor_valid;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: linear first estimate, wrapping modulo 2^32.
	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s1 <= norm_c;
			y_s2    <= rcpn_pkg::COEF_B - (rcpn_pkg::COEF_A * {17'd0, norm_s1.xn});
			norm_s2 <= norm_s1;
		end
	end

	assign chain_vld[0]  = vld_s2;
	assign chain_y[0]    = y_s2;
	assign chain_norm[0] = norm_s2;

	// Stages 3 to 8: the Newton refinements, two stages each.
	for (genvar k = 0; k < N; k++) begin : g_step
		rcpn_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.src_valid (chain_vld[k]),
			.src_y     (chain_y[k]),
			.src_norm  (chain_norm[k]),
			.res_valid (chain_vld[k+1]),
			.res_y     (chain_y[k+1]),
			.res_norm  (chain_norm[k+1])
		);
	end

	// Final stage: drop eight fraction bits and undo the normalizing shift. Bits
	// pushed above bit 31 by the left shift are lost, as in 32-bit arithmetic.
	assign y_trim = chain_y[N][31:8];
	assign fin_up = {8'd0, y_trim} << chain_norm[N].shl;
	assign fin_c  = fin_up >> chain_norm[N].shr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s9 <= chain_vld[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			reciprocal_s9 <= fin_c;
		end
	end

	assign reciprocal_valid = vld_s9;
	assign reciprocal       = reciprocal_s9;

	// A normalized value has its top bit set unless the divisor was zero.
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (norm_s1.xn[14] || norm_s1.xn == 15'd0))
		else $error("normalized divisor lost its top bit");

	// Only one direction of normalizing shift is ever used.
	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (norm_s1.shl == 4'd0 || norm_s1.shr == 2'd0))
		else $error("both left and right normalizing shifts are set");

	// While the pipeline is held, the first stage keeps its item.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(vld_s1) && (!vld_s1 || $stable(norm_s1))))
		else $error("first stage changed during a stall");

	// A result appears only after the pipeline has advanced.
	a_out_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s9) |-> $past(adv))
		else $error("result appeared without the pipeline advancing");

endmodule
